>>> design/esmc_pkg.sv
// Shared types, constants and the bytewise CRC-32 function for the
// event-stream message checker. No dependencies.
`default_nettype none

package esmc_pkg;

   localparam int unsigned PRELUDE_LEN = 12;
   localparam int unsigned MIN_LENGTH  = 16;

   localparam logic [31:0] CRC_POLY = 32'hEDB88320;
   localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

   localparam logic [7:0] TYPE_INT32  = 8'd4;
   localparam logic [7:0] TYPE_STRING = 8'd7;

   // region codes
   localparam logic [1:0] REGION_PRELUDE = 2'd0;
   localparam logic [1:0] REGION_HEADER  = 2'd1;
   localparam logic [1:0] REGION_PAYLOAD = 2'd2;
   localparam logic [1:0] REGION_TRAILER = 2'd3;

   // status codes
   localparam logic [2:0] STATUS_OK           = 3'd0;
   localparam logic [2:0] STATUS_PRELUDE_CRC  = 3'd1;
   localparam logic [2:0] STATUS_LENGTH_SMALL = 3'd2;
   localparam logic [2:0] STATUS_HEADERS_LONG = 3'd3;
   localparam logic [2:0] STATUS_MESSAGE_CRC  = 3'd4;
   localparam logic [2:0] STATUS_HDR_OVERRUN  = 3'd5;
   localparam logic [2:0] STATUS_BAD_TYPE     = 3'd6;

   typedef enum logic [2:0] {
      PH_NAME_LEN = 3'd0,
      PH_NAME     = 3'd1,
      PH_TYPE     = 3'd2,
      PH_INT      = 3'd3,
      PH_STR_HI   = 3'd4,
      PH_STR_LO   = 3'd5,
      PH_STR      = 3'd6
   } phase_type;

   typedef enum logic [1:0] {
      FAULT_NONE    = 2'd0,
      FAULT_OVERRUN = 2'd1,
      FAULT_TYPE    = 2'd2
   } fault_type;

   // header walker state, handed between top level and walker
   typedef struct packed {
      phase_type   phase;
      logic [15:0] field_remaining;
      logic [7:0]  string_len_high;
      logic [29:0] header_total;
      fault_type   fault;
   } hdr_state_type;

   localparam hdr_state_type HDR_RESET = '{
      phase:           PH_NAME_LEN,
      field_remaining: 16'd0,
      string_len_high: 8'd0,
      header_total:    30'd0,
      fault:           FAULT_NONE
   };

   // reflected CRC-32, one byte
   function automatic logic [31:0] crc32_byte(input logic [31:0] crc,
                                              input logic [7:0]  data);
      logic [31:0] r;
      r = crc ^ {24'd0, data};
      for (int i = 0; i < 8; i++) begin
         r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
      end
      return r;
   endfunction

endpackage

`default_nettype wire

>>> design/esmc_if.sv
// Valid/ready channel interfaces for the request and result streams.
// Depends on nothing.
`default_nettype none

interface esmc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;

   modport source (output valid, output data_byte, input ready);
   modport sink   (input valid, input data_byte, output ready);
endinterface

interface esmc_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  byte_out;
   logic [1:0]  region;
   logic        end_of_message;
   logic [2:0]  status;
   logic [29:0] header_count;
   logic [31:0] payload_length;

   modport source (output valid, output byte_out, output region,
                   output end_of_message, output status, output header_count,
                   output payload_length, input ready);
   modport sink   (input valid, input byte_out, input region,
                   input end_of_message, input status, input header_count,
                   input payload_length, output ready);
endinterface

`default_nettype wire

>>> design/event_stream_message_checker_unit.sv
// Event-stream message checker, top level.
// Depends on esmc_pkg, esmc_if (esmc_req_if, esmc_rsp_if), esmc_header_walker.
//
// Usage:
//  - req_chan carries one raw stream byte per request (data_byte).
//  - rsp_chan returns exactly one result per request: the byte, its region
//    (prelude, header, payload, trailer), an end-of-message flag with status,
//    the running header count and the payload length.
//  - Two register stages: the request lands in an input register, the
//    checker updates its state from it and writes the result register.
//  - Throughput is one byte per cycle while the receiver takes results,
//    since the bytewise CRC-32 and the header walker are both combinational.
//  - When the receiver stalls, the result register holds and one more
//    request is taken into the input register; after that req ready drops
//    until the result is taken.
//  - Synchronous active-high reset empties both stages and returns the
//    parser to byte 0 of a prelude with the CRC preset to all ones.
//  - After any end of message, good or failed, parsing restarts at the next
//    byte.
`default_nettype none

module event_stream_message_checker_unit (
   input  wire logic clock,
   input  wire logic reset,
   esmc_req_if.sink   req_chan,
   esmc_rsp_if.source rsp_chan
);

   // input stage
   logic       s1_valid_ff;
   logic [7:0] s1_byte_ff;
   logic       advance;

   // parser state
   logic [31:0] pos_ff, pos_in;
   logic [31:0] msg_len_ff, msg_len_in;
   logic [31:0] hdr_len_ff, hdr_len_in;
   logic [31:0] crc_ff, crc_in;
   logic [31:0] prelude_crc_ff, prelude_crc_in;
   logic [31:0] rx_crc_ff, rx_crc_in;
   logic [32:0] hdr_end_ff, hdr_end_in;     // first byte past the headers
   logic [32:0] hdr_last_ff, hdr_last_in;   // last header byte
   logic [31:0] trl_start_ff, trl_start_in;
   logic [31:0] msg_last_ff, msg_last_in;
   logic [31:0] pay_len_ff, pay_len_in;
   esmc_pkg::hdr_state_type hdr_ff, hdr_in, hdr_walk;

   // result register
   logic        rsp_valid_ff;
   logic [7:0]  rsp_byte_ff;
   logic [1:0]  rsp_region_ff, region;
   logic        rsp_eom_ff, eom;
   logic [2:0]  rsp_status_ff, status;
   logic [29:0] rsp_count_ff;
   logic [31:0] rsp_pay_ff, pay_out;

   logic [7:0]  b;
   logic [31:0] crc_step;
   logic [31:0] rx_crc_full;
   logic [31:0] pay_calc;
   logic        in_prelude;
   logic        hdr_last_byte;

   assign advance        = s1_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !s1_valid_ff || advance;

   assign b           = s1_byte_ff;
   assign crc_step    = esmc_pkg::crc32_byte(crc_ff, b);
   assign rx_crc_full = {rx_crc_ff[23:0], b};
   assign pay_calc    = msg_len_ff - 32'(esmc_pkg::MIN_LENGTH) - hdr_len_ff;
   assign in_prelude  = pos_ff < 32'(esmc_pkg::PRELUDE_LEN);
   assign hdr_last_byte = ({1'b0, pos_ff} == hdr_last_ff);

   esmc_header_walker u_walker (
      .cur       (hdr_ff),
      .data_byte (b),
      .last_byte (hdr_last_byte),
      .nxt       (hdr_walk)
   );

   always_comb begin
      pos_in         = pos_ff + 32'd1;
      msg_len_in     = msg_len_ff;
      hdr_len_in     = hdr_len_ff;
      crc_in         = crc_ff;
      prelude_crc_in = prelude_crc_ff;
      rx_crc_in      = rx_crc_ff;
      hdr_end_in     = hdr_end_ff;
      hdr_last_in    = hdr_last_ff;
      trl_start_in   = trl_start_ff;
      msg_last_in    = msg_last_ff;
      pay_len_in     = pay_len_ff;
      hdr_in         = hdr_ff;
      region         = esmc_pkg::REGION_PRELUDE;
      eom            = 1'b0;
      status         = esmc_pkg::STATUS_OK;
      pay_out        = 32'd0;

      if (in_prelude) begin
         // CRC runs over all twelve prelude bytes; the value after byte 7
         // is kept for the prelude check
         crc_in = crc_step;
         if (pos_ff < 32'd4) begin
            msg_len_in = {msg_len_ff[23:0], b};
         end else if (pos_ff < 32'd8) begin
            hdr_len_in = {hdr_len_ff[23:0], b};
         end else begin
            rx_crc_in = rx_crc_full;
         end
         if (pos_ff == 32'd7) prelude_crc_in = crc_step;

         if (pos_ff == 32'(esmc_pkg::PRELUDE_LEN - 1)) begin
            if (~prelude_crc_ff != rx_crc_full) begin
               status = esmc_pkg::STATUS_PRELUDE_CRC;
            end else if (msg_len_ff < 32'(esmc_pkg::MIN_LENGTH)) begin
               status = esmc_pkg::STATUS_LENGTH_SMALL;
            end else if (hdr_len_ff > msg_len_ff - 32'(esmc_pkg::MIN_LENGTH)) begin
               status = esmc_pkg::STATUS_HEADERS_LONG;
            end
            if (status != esmc_pkg::STATUS_OK) begin
               eom = 1'b1;
            end else begin
               pay_out      = pay_calc;
               pay_len_in   = pay_calc;
               hdr_end_in   = {1'b0, hdr_len_ff} + 33'(esmc_pkg::PRELUDE_LEN);
               hdr_last_in  = {1'b0, hdr_len_ff} + 33'(esmc_pkg::PRELUDE_LEN - 1);
               trl_start_in = msg_len_ff - 32'd4;
               msg_last_in  = msg_len_ff - 32'd1;
            end
         end
      end else begin
         pay_out = pay_len_ff;
         if ({1'b0, pos_ff} < hdr_end_ff) begin
            region = esmc_pkg::REGION_HEADER;
         end else if (pos_ff < trl_start_ff) begin
            region = esmc_pkg::REGION_PAYLOAD;
         end else begin
            region = esmc_pkg::REGION_TRAILER;
         end

         if (region == esmc_pkg::REGION_TRAILER) begin
            rx_crc_in = rx_crc_full;
            if (pos_ff >= msg_last_ff) begin
               eom = 1'b1;
               if (~crc_ff != rx_crc_full) begin
                  status = esmc_pkg::STATUS_MESSAGE_CRC;
               end else if (hdr_ff.fault == esmc_pkg::FAULT_OVERRUN) begin
                  status = esmc_pkg::STATUS_HDR_OVERRUN;
               end else if (hdr_ff.fault == esmc_pkg::FAULT_TYPE) begin
                  status = esmc_pkg::STATUS_BAD_TYPE;
               end
            end
         end else begin
            crc_in = crc_step;
            if (region == esmc_pkg::REGION_HEADER) hdr_in = hdr_walk;
         end
      end

      // restart on any end
      if (eom) begin
         pos_in = 32'd0;
         crc_in = esmc_pkg::CRC_INIT;
         hdr_in = esmc_pkg::HDR_RESET;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         s1_valid_ff <= req_chan.valid;
      end
      if (req_chan.ready) s1_byte_ff <= req_chan.data_byte;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= 32'd0;
         crc_ff <= esmc_pkg::CRC_INIT;
         hdr_ff <= esmc_pkg::HDR_RESET;
      end else if (advance) begin
         pos_ff <= pos_in;
         crc_ff <= crc_in;
         hdr_ff <= hdr_in;
      end
      if (advance) begin
         msg_len_ff     <= msg_len_in;
         hdr_len_ff     <= hdr_len_in;
         prelude_crc_ff <= prelude_crc_in;
         rx_crc_ff      <= rx_crc_in;
         hdr_end_ff     <= hdr_end_in;
         hdr_last_ff    <= hdr_last_in;
         trl_start_ff   <= trl_start_in;
         msg_last_ff    <= msg_last_in;
         pay_len_ff     <= pay_len_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (advance) begin
         rsp_byte_ff   <= b;
         rsp_region_ff <= region;
         rsp_eom_ff    <= eom;
         rsp_status_ff <= status;
         // count includes records closed by this byte
         rsp_count_ff  <= (region == esmc_pkg::REGION_HEADER) ? hdr_walk.header_total
                                                              : hdr_ff.header_total;
         rsp_pay_ff    <= pay_out;
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.byte_out       = rsp_byte_ff;
   assign rsp_chan.region         = rsp_region_ff;
   assign rsp_chan.end_of_message = rsp_eom_ff;
   assign rsp_chan.status         = rsp_status_ff;
   assign rsp_chan.header_count   = rsp_count_ff;
   assign rsp_chan.payload_length = rsp_pay_ff;

endmodule

`default_nettype wire

>>> design/esmc_header_walker.sv
// Next-state logic for the header record walker, one byte per call.
// Depends on esmc_pkg.
`default_nettype none

module esmc_header_walker (
   input  wire esmc_pkg::hdr_state_type cur,
   input  wire logic [7:0]              data_byte,
   input  wire logic                    last_byte,
   output esmc_pkg::hdr_state_type      nxt
);

   logic [15:0] dec;

   assign dec = cur.field_remaining - 16'd1;

   always_comb begin
      nxt = cur;
      if (cur.fault == esmc_pkg::FAULT_NONE) begin
         case (cur.phase)
            esmc_pkg::PH_NAME_LEN: begin
               if (data_byte == 8'd0) begin
                  nxt.phase = esmc_pkg::PH_TYPE;
               end else begin
                  nxt.field_remaining = {8'd0, data_byte};
                  nxt.phase           = esmc_pkg::PH_NAME;
               end
            end
            esmc_pkg::PH_NAME: begin
               nxt.field_remaining = dec;
               if (dec == 16'd0) nxt.phase = esmc_pkg::PH_TYPE;
            end
            esmc_pkg::PH_TYPE: begin
               if (data_byte == esmc_pkg::TYPE_INT32) begin
                  nxt.field_remaining = 16'd4;
                  nxt.phase           = esmc_pkg::PH_INT;
               end else if (data_byte == esmc_pkg::TYPE_STRING) begin
                  nxt.phase = esmc_pkg::PH_STR_HI;
               end else begin
                  nxt.fault = esmc_pkg::FAULT_TYPE;
               end
            end
            esmc_pkg::PH_STR_HI: begin
               nxt.string_len_high = data_byte;
               nxt.phase           = esmc_pkg::PH_STR_LO;
            end
            esmc_pkg::PH_STR_LO: begin
               nxt.field_remaining = {cur.string_len_high, data_byte};
               if ({cur.string_len_high, data_byte} == 16'd0) begin
                  nxt.header_total = cur.header_total + 30'd1;
                  nxt.phase        = esmc_pkg::PH_NAME_LEN;
               end else begin
                  nxt.phase = esmc_pkg::PH_STR;
               end
            end
            esmc_pkg::PH_INT, esmc_pkg::PH_STR: begin
               nxt.field_remaining = dec;
               if (dec == 16'd0) begin
                  nxt.header_total = cur.header_total + 30'd1;
                  nxt.phase        = esmc_pkg::PH_NAME_LEN;
               end
            end
            default: begin
               nxt.phase = esmc_pkg::PH_NAME_LEN;
            end
         endcase
      end
      // record still open when the header region closes
      if (last_byte && nxt.fault == esmc_pkg::FAULT_NONE &&
          nxt.phase != esmc_pkg::PH_NAME_LEN) begin
         nxt.fault = esmc_pkg::FAULT_OVERRUN;
      end
   end

endmodule

`default_nettype wire
